[design/scbp_pkg.sv]
// Shared types, codes and sizing for the size class buffer pool.
// No dependencies; every other file of the block imports this package.
package scbp_pkg;

   // Pool sizing
   localparam int SMALL_COUNT  = 16;
   localparam int MEDIUM_COUNT = 16;
   localparam int BIG_COUNT    = 16;
   localparam int CLASS_COUNT  = 3;
   localparam int TOTAL_COUNT  = SMALL_COUNT + MEDIUM_COUNT + BIG_COUNT;

   localparam int SMALL_FIRST  = 0;
   localparam int MEDIUM_FIRST = SMALL_COUNT;
   localparam int BIG_FIRST    = SMALL_COUNT + MEDIUM_COUNT;

   // Field widths
   localparam int IDX_W     = 6;
   localparam int BYTES_W   = 16;
   localparam int CLASS_W   = 2;
   localparam int STATUS_W  = 2;
   localparam int CSR_IDX_W = 2;

   // Register reset values
   localparam logic [BYTES_W-1:0] SMALL_BYTES_RESET  = BYTES_W'(64);
   localparam logic [BYTES_W-1:0] MEDIUM_BYTES_RESET = BYTES_W'(256);
   localparam logic [BYTES_W-1:0] BIG_BYTES_RESET    = BYTES_W'(1024);

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] REG_SMALL_BYTES  = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_MEDIUM_BYTES = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] REG_BIG_BYTES    = CSR_IDX_W'(2);

   // Command queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic {
      OP_REQUEST = 1'b0,
      OP_RELEASE = 1'b1
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK     = 2'd0,
      ST_NO_FIT = 2'd1,
      ST_EMPTY  = 2'd2
   } status_type;

   typedef enum logic [CLASS_W-1:0] {
      CLS_SMALL  = 2'd0,
      CLS_MEDIUM = 2'd1,
      CLS_BIG    = 2'd2
   } class_type;

   typedef enum logic {
      BK_IDLE = 1'b0,
      BK_POP  = 1'b1
   } state_type;

   // Classified operation handed from front to back
   typedef struct packed {
      op_type           op;
      logic             fits;
      class_type        cls;
      logic [IDX_W-1:0] idx;
   } cmd_type;

   // End-of-list marks after reset: clear only on the last index of a class
   function automatic logic [TOTAL_COUNT-1:0] link_valid_reset();
      logic [TOTAL_COUNT-1:0] v;
      for (int i = 0; i < TOTAL_COUNT; i++) begin
         v[i] = !((i == SMALL_COUNT - 1) || (i == BIG_FIRST - 1) || (i == TOTAL_COUNT - 1));
      end
      return v;
   endfunction

endpackage

[design/scbp_if.sv]
// Channel interfaces of the size class buffer pool: request, response, register write.
// Depends on scbp_pkg for field widths.
interface scbp_req_if import scbp_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               opcode;
   logic [BYTES_W-1:0] request_bytes;
   logic [IDX_W-1:0]   buffer_index;
   logic [BYTES_W-1:0] buffer_bytes;

   modport source (output valid, opcode, request_bytes, buffer_index, buffer_bytes,
                   input ready);
   modport sink   (input valid, opcode, request_bytes, buffer_index, buffer_bytes,
                   output ready);
endinterface

interface scbp_rsp_if import scbp_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [IDX_W-1:0]    granted_index;
   logic [CLASS_W-1:0]  class_used;

   modport source (output valid, status, granted_index, class_used, input ready);
   modport sink   (input valid, status, granted_index, class_used, output ready);
endinterface

interface scbp_csr_if import scbp_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [BYTES_W-1:0]   data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

[design/size_class_buffer_pool_top.sv]
// Top level of the size class buffer pool: front end, command queue, free list engine.
// Depends on scbp_pkg, scbp_if.sv, scbp_front, scbp_queue and scbp_back.
//
//   channel  port    dir  handshake    payload
//   request  req_ch  in   valid/ready  opcode, request_bytes, buffer_index, buffer_bytes
//   result   rsp_ch  out  valid/ready  status, granted_index, class_used
//   config   csr_ch  in   valid/ready  index, data (always ready)
//
// A successful request passes through the idle and pop states: the head's successor is read
// from the registered link memory before the class head can move. Releases and failed
// requests finish in the idle state. An accepted item is stored in the queue before the
// engine loads its result into the result register.
// Reset is synchronous; per-entry valid bits stand in for the initial link chain, so
// there is no clearing pass. A stalled result holds the engine while the 2-entry queue
// keeps accepting items until it fills.
module size_class_buffer_pool_top import scbp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   scbp_req_if.sink    req_ch,
   scbp_rsp_if.source  rsp_ch,
   scbp_csr_if.sink    csr_ch
);

   logic    q_push, q_pop, q_full, q_valid;
   cmd_type push_cmd, head_cmd;

   scbp_front u_front (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .csr_ch (csr_ch),
      .q_full (q_full),
      .q_push (q_push),
      .q_cmd  (push_cmd)
   );

   scbp_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (push_cmd),
      .pop      (q_pop),
      .full     (q_full),
      .valid    (q_valid),
      .head     (head_cmd)
   );

   scbp_back u_back (
      .clock   (clock),
      .reset   (reset),
      .q_valid (q_valid),
      .q_cmd   (head_cmd),
      .q_pop   (q_pop),
      .rsp_ch  (rsp_ch)
   );

endmodule

[design/scbp_front.sv]
// Front end: holds the class size registers, accepts items and picks their class.
// Depends on scbp_pkg and the channel interfaces in scbp_if.sv.
module scbp_front import scbp_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   scbp_req_if.sink      req_ch,
   scbp_csr_if.sink      csr_ch,
   input  logic          q_full,
   output logic          q_push,
   output cmd_type       q_cmd
);

   logic [BYTES_W-1:0]     size_ff [CLASS_COUNT];
   logic [BYTES_W-1:0]     size_in [CLASS_COUNT];
   logic [BYTES_W-1:0]     sel_bytes;
   logic [CLASS_COUNT-1:0] fit;

   // Register writes are always taken
   assign csr_ch.ready = 1'b1;

   always_comb begin
      size_in = size_ff;
      if (csr_ch.valid && csr_ch.ready) begin
         unique case (csr_ch.index)
            REG_SMALL_BYTES:  size_in[CLS_SMALL]  = csr_ch.data;
            REG_MEDIUM_BYTES: size_in[CLS_MEDIUM] = csr_ch.data;
            REG_BIG_BYTES:    size_in[CLS_BIG]    = csr_ch.data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff[CLS_SMALL]  <= SMALL_BYTES_RESET;
         size_ff[CLS_MEDIUM] <= MEDIUM_BYTES_RESET;
         size_ff[CLS_BIG]    <= BIG_BYTES_RESET;
      end else begin
         size_ff <= size_in;
      end
   end

   // Size compare: first class from small to big whose buffers are big enough
   assign sel_bytes = (req_ch.opcode == OP_REQUEST) ? req_ch.request_bytes
                                                    : req_ch.buffer_bytes;
   assign fit[CLS_SMALL]  = size_ff[CLS_SMALL]  >= sel_bytes;
   assign fit[CLS_MEDIUM] = size_ff[CLS_MEDIUM] >= sel_bytes;
   assign fit[CLS_BIG]    = size_ff[CLS_BIG]    >= sel_bytes;

   always_comb begin
      q_cmd.op   = op_type'(req_ch.opcode);
      q_cmd.fits = |fit;
      q_cmd.idx  = req_ch.buffer_index;
      if (fit[CLS_SMALL]) begin
         q_cmd.cls = CLS_SMALL;
      end else if (fit[CLS_MEDIUM]) begin
         q_cmd.cls = CLS_MEDIUM;
      end else begin
         q_cmd.cls = CLS_BIG;
      end
   end

   // Accept whenever the queue has room
   assign req_ch.ready = !q_full;
   assign q_push       = req_ch.valid && req_ch.ready;

endmodule

[design/scbp_queue.sv]
// Short command queue between the front end and the free list engine.
// Depends on scbp_pkg for the command type and depth.
module scbp_queue import scbp_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   input  logic    pop,
   output logic    full,
   output logic    valid,
   output cmd_type head
);

   cmd_type             entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;

   assign full  = count_ff == QCNT_W'(QUEUE_DEPTH);
   assign valid = count_ff != '0;
   assign head  = entry_ff[rd_ptr_ff];

   // Pointer wrap and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Payload storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

[design/scbp_back.sv]
// Free list engine: class heads, end-of-list marks, link memory and response register.
// Depends on scbp_pkg and the response interface in scbp_if.sv.
module scbp_back import scbp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        q_valid,
   input  cmd_type     q_cmd,
   output logic        q_pop,
   scbp_rsp_if.source  rsp_ch
);

   state_type              state_ff, state_in;
   class_type              cur_ff, cur_in;
   logic [IDX_W-1:0]       head_ff [CLASS_COUNT];
   logic [IDX_W-1:0]       head_in [CLASS_COUNT];
   logic [CLASS_COUNT-1:0] nonempty_ff, nonempty_in;
   logic [TOTAL_COUNT-1:0] lv_ff, lv_in;
   logic [TOTAL_COUNT-1:0] written_ff, written_in;

   // Link memory and its registered read port
   logic [IDX_W-1:0]       link_mem [TOTAL_COUNT];
   logic [IDX_W-1:0]       rd_data_ff;
   logic                   rd_written_ff;
   logic                   rd_en, wr_en;
   logic [IDX_W-1:0]       rd_addr, wr_addr, wr_data;

   // Response register
   logic                   rsp_valid_ff, rsp_valid_in;
   status_type             status_ff, status_in;
   logic [IDX_W-1:0]       granted_ff, granted_in;
   class_type              class_ff, class_in;
   logic                   rsp_load;
   logic                   out_free;
   logic [IDX_W-1:0]       pop_head;

   assign out_free = !rsp_valid_ff || rsp_ch.ready;
   assign pop_head = head_ff[cur_ff];
   assign rd_addr  = head_ff[q_cmd.cls];
   assign wr_addr  = q_cmd.idx;
   assign wr_data  = head_ff[q_cmd.cls];

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_IDLE: begin
            if (q_valid && out_free && q_cmd.fits && (q_cmd.op == OP_REQUEST)
                && nonempty_ff[q_cmd.cls]) begin
               state_in = BK_POP;
            end
         end
         BK_POP: begin
            if (out_free) begin
               state_in = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   // Actions and state updates
   always_comb begin
      q_pop       = 1'b0;
      rd_en       = 1'b0;
      wr_en       = 1'b0;
      rsp_load    = 1'b0;
      status_in   = ST_OK;
      granted_in  = '0;
      class_in    = CLS_SMALL;
      cur_in      = cur_ff;
      head_in     = head_ff;
      nonempty_in = nonempty_ff;
      lv_in       = lv_ff;
      written_in  = written_ff;
      unique case (state_ff)
         BK_IDLE: begin
            if (q_valid && out_free) begin
               q_pop = 1'b1;
               if (!q_cmd.fits) begin
                  rsp_load  = 1'b1;
                  status_in = ST_NO_FIT;
               end else if (q_cmd.op == OP_REQUEST) begin
                  class_in = q_cmd.cls;
                  if (!nonempty_ff[q_cmd.cls]) begin
                     rsp_load  = 1'b1;
                     status_in = ST_EMPTY;
                  end else begin
                     // fetch the head's successor; finish next cycle
                     rd_en  = 1'b1;
                     cur_in = q_cmd.cls;
                  end
               end else begin
                  rsp_load = 1'b1;
                  class_in = q_cmd.cls;
                  // push; an index outside the pool is dropped
                  if (q_cmd.idx < IDX_W'(TOTAL_COUNT)) begin
                     wr_en                  = 1'b1;
                     lv_in[q_cmd.idx]       = nonempty_ff[q_cmd.cls];
                     written_in[q_cmd.idx]  = 1'b1;
                     head_in[q_cmd.cls]     = q_cmd.idx;
                     nonempty_in[q_cmd.cls] = 1'b1;
                  end
               end
            end
         end
         BK_POP: begin
            if (out_free) begin
               rsp_load            = 1'b1;
               class_in            = cur_ff;
               granted_in          = pop_head;
               nonempty_in[cur_ff] = lv_ff[pop_head];
               // an entry never written still holds its reset successor
               head_in[cur_ff]     = rd_written_ff ? rd_data_ff : pop_head + 1'b1;
               lv_in[pop_head]     = 1'b0;
            end
         end
         default: ;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff            <= BK_IDLE;
         cur_ff              <= CLS_SMALL;
         head_ff[CLS_SMALL]  <= IDX_W'(SMALL_FIRST);
         head_ff[CLS_MEDIUM] <= IDX_W'(MEDIUM_FIRST);
         head_ff[CLS_BIG]    <= IDX_W'(BIG_FIRST);
         nonempty_ff         <= '1;
         lv_ff               <= link_valid_reset();
         written_ff          <= '0;
         rsp_valid_ff        <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cur_ff       <= cur_in;
         head_ff      <= head_in;
         nonempty_ff  <= nonempty_in;
         lv_ff        <= lv_in;
         written_ff   <= written_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Response payload
   always_ff @(posedge clock) begin
      if (rsp_load) begin
         status_ff  <= status_in;
         granted_ff <= granted_in;
         class_ff   <= class_in;
      end
   end

   // Link memory
   always_ff @(posedge clock) begin
      if (wr_en) begin
         link_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff    <= link_mem[rd_addr];
         rd_written_ff <= written_ff[rd_addr];
      end
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.status        = status_ff;
   assign rsp_ch.granted_index = granted_ff;
   assign rsp_ch.class_used    = class_ff;

`ifndef NO_ASSERTIONS
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      state_ff == BK_POP |-> nonempty_ff[cur_ff])
      else $error("pop pending on an empty class");

   a_pop_head_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == BK_POP |-> head_ff[cur_ff] < IDX_W'(TOTAL_COUNT))
      else $error("pop head outside the pool");

   a_pop_after_read: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BK_POP && $past(state_ff) == BK_IDLE) |-> $past(rd_en))
      else $error("pop entered without a link read");

   a_push_single: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (state_ff == BK_IDLE && rsp_load && !rd_en && q_pop))
      else $error("push outside a one-cycle release");
`endif

endmodule
